FILE: hdl/ers_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ers_pkg;

  localparam int MAX_EXTENTS = 256;
  localparam int FRAC_BITS   = 8;

  localparam int START_W = 40;
  localparam int LEN_W   = 32;
  localparam int CFG_W   = 24;
  localparam int SEV_W   = 16;
  localparam int IDX_W   = 2;

  localparam int ADDR_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_EXTENTS + 1);
  localparam int ENTRY_W = START_W + LEN_W;
  // Every visited extent adds at most one 24-bit length share and one 24-bit term.
  localparam int COST_W  = CFG_W + CNT_W + 1;
  localparam int DVD_W   = COST_W + FRAC_BITS;
  localparam int IDEAL_W = CFG_W + 1;
  localparam int WORST_W = SEV_W + 1;
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  localparam logic [CFG_W-1:0] WINDOW_RESET  = CFG_W'(512);
  localparam logic [CFG_W-1:0] GAP_RESET     = CFG_W'(16);
  localparam logic [CFG_W-1:0] PENALTY_RESET = CFG_W'(195);

  localparam logic [IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAP     = 2'd1;
  localparam logic [IDX_W-1:0] REG_PENALTY = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_FETCH    = 10'b0000000010,
    S_CUR      = 10'b0000000100,
    S_EVAL     = 10'b0000001000,
    S_STEP     = 10'b0000010000,
    S_ACC      = 10'b0000100000,
    S_DIV_INIT = 10'b0001000000,
    S_DIV      = 10'b0010000000,
    S_UPD      = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic job_init;
    logic walk_init;
    logic cur_load;
    logic eval;
    logic step;
    logic acc;
    logic div_init;
    logic div_step;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic span_zero;
    logic walk_more;
    logic ideal_zero;
    logic div_last;
    logic k_more;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/extent_read_severity.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel     Handshake             Payload
// extent in   start / busy          extent_start, extent_length, last
// config      cfg_valid / cfg_ready cfg_index, cfg_data
// result      done (one cycle)      severity_q8, fragmented, overflow
//
// An extent is transferred whenever the block is idle, so a file's list loads at one
// extent per clock. After the last extent, each starting extent runs the fetch states
// S_FETCH and S_CUR, the walk states S_EVAL, S_STEP and S_ACC per visited extent, a
// set-up state, a restoring division (left out when the ideal cost is zero) and an
// update state; the single store read port sets the walk speed. S_OUT strobes done.
// Reset (rst, synchronous) empties the list and restores the registers; no stalls.
module extent_read_severity
  import ers_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [START_W-1:0] extent_start,
  input  wire logic [LEN_W-1:0]   extent_length,
  input  wire logic               last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output logic                    done,
  output logic      [SEV_W-1:0]   severity_q8,
  output logic                    fragmented,
  output logic                    overflow
);

  cmd_t    cmd;
  status_t status;

  // Configuration transfers are taken in every cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences loading, the window walk and the division.
  ers_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the extent store, the walk registers and the divider.
  ers_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .extent_start (extent_start),
    .extent_length(extent_length),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .severity_q8  (severity_q8),
    .fragmented   (fragmented),
    .overflow     (overflow)
  );

`ifndef SYNTHESIS
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("result not followed by idle");
  a_sev_floor: assert property (@(posedge clk) disable iff (rst)
    done |-> (severity_q8 >= SEV_W'(1 << FRAC_BITS))) else $error("severity below one");
  a_frag: assert property (@(posedge clk) disable iff (rst)
    (done && fragmented) |-> (severity_q8 >= SEV_W'(2 << FRAC_BITS)))
    else $error("fragmented flag without severity two");
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !busy) else $error("busy after plain extent");
`endif

endmodule
`default_nettype wire

FILE: hdl/ers_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ers_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ers_ctrl
  import ers_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    last,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.job_init = 1'b1;
            state_next   = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.walk_init = 1'b1;
        state_next    = S_CUR;
      end
      S_CUR: begin
        cmd.cur_load = 1'b1;
        state_next   = status.span_zero ? S_DIV_INIT : S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.walk_more ? S_EVAL : S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = status.ideal_zero ? S_UPD : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = status.k_more ? S_FETCH : S_OUT;
      end
      S_OUT: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule
`default_nettype wire

FILE: hdl/ers_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ers_dp
  import ers_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [START_W-1:0] extent_start,
  input  wire logic [LEN_W-1:0]   extent_length,
  input  wire logic               cfg_valid,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output logic      [SEV_W-1:0]   severity_q8,
  output logic                    fragmented,
  output logic                    overflow
);

  logic [CFG_W-1:0]   win, gap_lim, pen;
  logic [CNT_W-1:0]   count, k, j;
  logic               dropped;
  logic [CFG_W-1:0]   span;
  logic [COST_W-1:0]  cost;
  logic [START_W-1:0] cur_start;
  logic [LEN_W-1:0]   cur_len;
  logic [START_W:0]   end_r;
  logic               has_next;
  logic [CFG_W-1:0]   term;
  logic [IDEAL_W-1:0] divisor, rem;
  logic [DVD_W-1:0]   quo;
  logic [DCNT_W-1:0]  div_cnt;
  logic [WORST_W-1:0] worst;

  logic [ENTRY_W-1:0] rd_data;
  logic [CNT_W-1:0]   j_plus, k_plus;
  logic               room;
  logic [START_W-1:0] next_start;
  logic [START_W:0]   gap_diff;
  logic               gap_ok, fits;
  logic [CFG_W-1:0]   take;
  logic [IDEAL_W-1:0] ideal_c;
  logic [IDEAL_W:0]   trial;
  logic               q_bit;
  logic [WORST_W-1:0] q_clamp;

  assign j_plus     = j + 1'b1;
  assign k_plus     = k + 1'b1;
  assign room       = (count < CNT_W'(MAX_EXTENTS));
  assign next_start = rd_data[ENTRY_W-1:LEN_W];
  assign gap_diff   = {1'b0, next_start} - end_r;
  assign gap_ok     = ({1'b0, next_start} >= end_r)
                      && (gap_diff <= {{(START_W + 1 - CFG_W){1'b0}}, gap_lim});
  assign fits       = (cur_len <= {{(LEN_W - CFG_W){1'b0}}, span});
  assign take       = fits ? cur_len[CFG_W-1:0] : span;
  assign ideal_c    = {1'b0, win - span} + {1'b0, pen};
  assign trial      = {rem, quo[DVD_W-1]};
  assign q_bit      = (trial >= {1'b0, divisor});
  assign q_clamp    = (|quo[DVD_W-1:SEV_W]) ? {1'b1, {SEV_W{1'b0}}}
                                            : {1'b0, quo[SEV_W-1:0]};

  ers_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_EXTENTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.load && room),
    .wr_addr(count[ADDR_W-1:0]),
    .wr_data({extent_start, extent_length}),
    .rd_en  (cmd.walk_init || cmd.eval),
    .rd_addr(cmd.walk_init ? k[ADDR_W-1:0] : j_plus[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= WINDOW_RESET;
      gap_lim <= GAP_RESET;
      pen     <= PENALTY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW:  win     <= cfg_data;
        REG_GAP:     gap_lim <= cfg_data;
        REG_PENALTY: pen     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.finish) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count <= count + 1'b1;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.job_init) begin
      k     <= '0;
      worst <= WORST_W'(1 << FRAC_BITS);
    end
    if (cmd.walk_init) begin
      j    <= k;
      span <= win;
      cost <= COST_W'(pen);
    end
    if (cmd.cur_load) begin
      cur_start <= next_start;
      cur_len   <= rd_data[LEN_W-1:0];
    end
    if (cmd.eval) begin
      end_r    <= {1'b0, cur_start} + {{(START_W + 1 - LEN_W){1'b0}}, cur_len};
      has_next <= (j_plus < count);
    end
    if (cmd.step) begin
      cost <= cost + COST_W'(take);
      span <= fits ? span - take : '0;
      if (fits && has_next) begin
        term <= gap_ok ? gap_diff[CFG_W-1:0] : pen;
      end else begin
        term <= '0;
      end
      cur_start <= next_start;
      cur_len   <= rd_data[LEN_W-1:0];
      j         <= j_plus;
    end
    if (cmd.acc) begin
      cost <= cost + COST_W'(term);
    end
    if (cmd.div_init) begin
      divisor <= ideal_c;
      rem     <= '0;
      quo     <= {cost, {FRAC_BITS{1'b0}}};
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= q_bit ? IDEAL_W'(trial - {1'b0, divisor}) : trial[IDEAL_W-1:0];
      quo     <= {quo[DVD_W-2:0], q_bit};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.update) begin
      if ((divisor != '0) && (q_clamp > worst)) begin
        worst <= q_clamp;
      end
      k <= k_plus;
    end
  end

  always_comb begin
    status.span_zero  = (span == '0);
    status.walk_more  = (span != '0) && (j < count);
    status.ideal_zero = (ideal_c == '0);
    status.div_last   = (div_cnt == DCNT_W'(DVD_W - 1));
    status.k_more     = (k_plus < count);
  end

  assign severity_q8 = worst[SEV_W] ? {SEV_W{1'b1}} : worst[SEV_W-1:0];
  assign fragmented  = (worst >= WORST_W'(2 << FRAC_BITS));
  assign overflow    = dropped;

endmodule
`default_nettype wire
